@@ src/jbq_pkg.sv @@
// shared constants, quantization tables and stage payload types for the block quantizer
package jbq_pkg;

  localparam int BLOCK_SIZE  = 8;
  localparam int BLOCK_AREA  = BLOCK_SIZE * BLOCK_SIZE;
  localparam int POS_W       = 6;
  localparam int VALUE_W     = 16;
  localparam int RESULT_W    = 23;
  localparam int Q_W         = 7;
  localparam int MAG_W       = 16;
  // numerator after the divide by 32 folded into a shift
  localparam int NUM_W       = 12;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int LEVEL_W     = 8;
  localparam int BACK_W      = LEVEL_W + Q_W;
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 24;
  localparam int TUSER_IN_W  = 2;

  typedef enum logic {
    OP_QUANT   = 1'b0,
    OP_DEQUANT = 1'b1
  } op_t;

  localparam logic TABLE_CHROMA = 1'b0;
  localparam logic TABLE_LUMA   = 1'b1;

  localparam logic [Q_W-1:0] LUMA_Q [BLOCK_AREA] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd82,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [Q_W-1:0] CHROMA_Q [BLOCK_AREA] = '{
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  // operands after table lookup
  typedef struct packed {
    op_t                        op;
    logic                       neg;
    logic [Q_W-1:0]             q;
    logic [NUM_W-1:0]           num;
    logic [RECIP_W-1:0]         recip;
    logic signed [VALUE_W-1:0]  value;
  } prep_t;

  // quotient estimate and dequantized product
  typedef struct packed {
    op_t                        op;
    logic                       neg;
    logic [Q_W-1:0]             q;
    logic [NUM_W-1:0]           num;
    logic [LEVEL_W-1:0]         est;
    logic signed [RESULT_W-1:0] deq;
  } est_t;

  // estimate with its correction bit
  typedef struct packed {
    op_t                        op;
    logic                       neg;
    logic [LEVEL_W-1:0]         est;
    logic                       bump;
    logic signed [RESULT_W-1:0] deq;
  } fix_t;

endpackage

@@ src/jbq_prep.sv @@
// first stage: table lookup, magnitude and rounding numerator
module jbq_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jbq_pkg::op_t                  in_op,
  input  logic                          in_table,
  input  logic [jbq_pkg::POS_W-1:0]     in_position,
  input  logic signed [jbq_pkg::VALUE_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jbq_pkg::prep_t                out
);
  import jbq_pkg::*;

  logic [RECIP_W-1:0] recip_luma   [BLOCK_AREA];
  logic [RECIP_W-1:0] recip_chroma [BLOCK_AREA];
  logic [Q_W-1:0]     q;
  logic [RECIP_W-1:0] recip;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W:0]     sum;
  prep_t              prep;

  // truncated reciprocals of every table entry, fixed at elaboration
  for (genvar i = 0; i < BLOCK_AREA; i++) begin : g_recip
    localparam int RecipLuma   = RECIP_ONE / int'(LUMA_Q[i]);
    localparam int RecipChroma = RECIP_ONE / int'(CHROMA_Q[i]);
    assign recip_luma[i]   = RECIP_W'(RecipLuma);
    assign recip_chroma[i] = RECIP_W'(RecipChroma);
  end

  // table entry and its reciprocal
  always_comb begin
    if (in_table == TABLE_LUMA) begin
      q     = LUMA_Q[in_position];
      recip = recip_luma[in_position];
    end else begin
      q     = CHROMA_Q[in_position];
      recip = recip_chroma[in_position];
    end
  end

  // (2|v| + 16q) / 32 reduces to (|v| + 8q) >> 4 under the outer floor
  assign neg = in_value[VALUE_W-1];
  assign mag = neg ? MAG_W'(-in_value) : MAG_W'(in_value);
  assign sum = {1'b0, mag} + (MAG_W+1)'({q, 3'b000});

  always_comb begin
    prep.op    = in_op;
    prep.neg   = neg;
    prep.q     = q;
    prep.num   = sum[NUM_W+3:4];
    prep.recip = recip;
    prep.value = in_value;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out <= prep;
    end
  end

endmodule

@@ src/jbq_mult.sv @@
// second stage: reciprocal multiply for the quotient estimate, level times entry
module jbq_mult (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jbq_pkg::prep_t in,
  output logic           out_valid,
  input  logic           out_ready,
  output jbq_pkg::est_t  out
);
  import jbq_pkg::*;

  logic [PROD_W-1:0]          prod;
  logic signed [RESULT_W-1:0] deq;
  est_t                       est;

  // estimate is the true quotient or one below it
  assign prod = PROD_W'(in.num) * PROD_W'(in.recip);

  assign deq = $signed({{(RESULT_W-VALUE_W){in.value[VALUE_W-1]}}, in.value})
             * $signed({{(RESULT_W-Q_W){1'b0}}, in.q});

  always_comb begin
    est.op  = in.op;
    est.neg = in.neg;
    est.q   = in.q;
    est.num = in.num;
    est.est = prod[RECIP_SHIFT +: LEVEL_W];
    est.deq = deq;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out <= est;
    end
  end

endmodule

@@ src/jbq_fix.sv @@
// third stage: remainder check that corrects the quotient estimate
module jbq_fix (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  jbq_pkg::est_t in,
  output logic          out_valid,
  input  logic          out_ready,
  output jbq_pkg::fix_t out
);
  import jbq_pkg::*;

  logic [BACK_W-1:0] back;
  logic [BACK_W-1:0] rem;
  fix_t              fix;

  // remainder of the estimate, bumped when it reaches the divisor
  assign back = BACK_W'(in.est) * BACK_W'(in.q);
  assign rem  = BACK_W'(in.num) - back;

  always_comb begin
    fix.op   = in.op;
    fix.neg  = in.neg;
    fix.est  = in.est;
    fix.bump = (rem >= BACK_W'(in.q));
    fix.deq  = in.deq;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out <= fix;
    end
  end

endmodule

@@ src/jpeg_block_quantizer.sv @@
// top level of the 8x8 block quantizer and dequantizer
//
// One coefficient or level enters per beat on the slave stream, with its
// row-major position in the 8x8 block, the table choice and the operation.
// Quantize divides a coefficient carrying 4 fractional bits by the luma or
// chroma table entry and rounds half away from zero; dequantize multiplies
// an integer level by the entry. One result beat leaves per input beat, in
// order, on the master stream.
// An input beat passes through lookup, reciprocal multiply, remainder
// correction and the output register. Throughput is one beat per cycle
// while the receiver keeps m_tready high, set by the four-stage pipeline
// where every stage takes a new item each cycle unless it is stalled.
// When the receiver stalls, the result holds in the output register and
// the earlier stages keep filling until all four are full; only then does
// s_tready drop. Empty stages never hold up the input.
// Reset clears the stage valid bits; the block keeps no other state.
module jpeg_block_quantizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // position [5:0], value [21:6], zero [23:22]
  input  logic [jbq_pkg::TDATA_IN_W-1:0]     s_tdata,
  // opcode [0], table_select [1]
  input  logic [jbq_pkg::TUSER_IN_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // result [22:0], zero [23]
  output logic [jbq_pkg::TDATA_OUT_W-1:0]    m_tdata
);
  import jbq_pkg::*;

  logic                       prep_valid;
  logic                       prep_ready;
  prep_t                      prep;
  logic                       est_valid;
  logic                       est_ready;
  est_t                       est;
  logic                       fix_valid;
  logic                       fix_ready;
  fix_t                       fix;
  logic [LEVEL_W-1:0]         level;
  logic signed [RESULT_W-1:0] quant;
  logic signed [RESULT_W-1:0] result_next;
  logic signed [RESULT_W-1:0] result;
  op_t                        out_op;

  jbq_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (op_t'(s_tuser[0])),
    .in_table    (s_tuser[1]),
    .in_position (s_tdata[POS_W-1:0]),
    .in_value    ($signed(s_tdata[POS_W +: VALUE_W])),
    .out_valid   (prep_valid),
    .out_ready   (prep_ready),
    .out         (prep)
  );

  jbq_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in        (prep),
    .out_valid (est_valid),
    .out_ready (est_ready),
    .out       (est)
  );

  jbq_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (est_valid),
    .in_ready  (est_ready),
    .in        (est),
    .out_valid (fix_valid),
    .out_ready (fix_ready),
    .out       (fix)
  );

  // corrected level with the coefficient sign applied
  assign level       = fix.est + LEVEL_W'(fix.bump);
  assign quant       = fix.neg ? -$signed(RESULT_W'(level)) : $signed(RESULT_W'(level));
  assign result_next = (fix.op == OP_DEQUANT) ? fix.deq : quant;

  assign fix_ready = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fix_ready) begin
      m_tvalid <= fix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fix_valid && fix_ready) begin
      result <= result_next;
      out_op <= fix.op;
    end
  end

  assign m_tdata = {{(TDATA_OUT_W-RESULT_W){1'b0}}, result};

  // a ready receiver never backs up the pipeline
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while the receiver was ready");

  // input only stalls when every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && prep_valid && est_valid && fix_valid))
    else $error("input stalled with a free pipeline stage");

  // quantized levels stay within the table-limited range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_op == OP_QUANT) |->
      (result <= 23'sd205 && result >= -23'sd205))
    else $error("quantized level out of range");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

@@ verif/tb_jpeg_block_quantizer.sv @@
// testbench for the block quantizer: streams coefficients and levels, predicts and checks results
module tb_jpeg_block_quantizer;
  timeunit 1ns;
  timeprecision 1ps;

  import jbq_pkg::*;

  // expected results of quantize and dequantize beats, oldest first
  class quant_scoreboard;
    int unsigned luma_tbl[64];
    int unsigned chroma_tbl[64];
    logic [RESULT_W-1:0] expected_results[$];
    int errors;

    function new();
      luma_tbl = '{
        16, 11, 10, 16, 24, 40, 51, 61,
        12, 12, 14, 19, 26, 58, 60, 55,
        14, 13, 16, 24, 40, 57, 69, 56,
        14, 17, 22, 29, 51, 87, 80, 82,
        18, 22, 37, 56, 68, 109, 103, 77,
        24, 35, 55, 64, 81, 104, 113, 92,
        49, 64, 78, 87, 103, 121, 120, 101,
        72, 92, 95, 98, 112, 100, 103, 99};
      chroma_tbl = '{
        17, 18, 24, 47, 99, 99, 99, 99,
        18, 21, 26, 66, 99, 99, 99, 99,
        24, 26, 56, 99, 99, 99, 99, 99,
        47, 66, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99};
      errors = 0;
    endfunction

    function int step_size(logic tsel, logic [POS_W-1:0] pos);
      return (tsel == TABLE_LUMA) ? int'(luma_tbl[pos]) : int'(chroma_tbl[pos]);
    endfunction

    // round half away from zero of (v/16)/q, or v*q
    function logic [RESULT_W-1:0] scaled_result(op_t op, logic tsel, logic [POS_W-1:0] pos,
                                                logic signed [VALUE_W-1:0] v);
      int q;
      int mag;
      int lvl;
      int r;
      q = step_size(tsel, pos);
      if (op == OP_QUANT) begin
        mag = (v < 0) ? -int'(v) : int'(v);
        lvl = (2 * mag + 16 * q) / (32 * q);
        r = (v < 0) ? -lvl : lvl;
      end else begin
        r = int'(v) * q;
      end
      return r[RESULT_W-1:0];
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_input(op_t op, logic tsel, logic [POS_W-1:0] pos,
                             logic signed [VALUE_W-1:0] v);
      expected_results.push_back(scaled_result(op, tsel, pos, v));
    endfunction

    task check_result(logic [TDATA_OUT_W-1:0] beat);
      logic [RESULT_W-1:0] want;
      if (expected_results.size() == 0) begin
        report($sformatf("result beat 0x%06h with nothing expected", beat));
      end else begin
        want = expected_results.pop_front();
        if (beat[RESULT_W-1:0] !== want)
          report($sformatf("result 0x%06h, expected 0x%06h", beat[RESULT_W-1:0], want));
        if (beat[TDATA_OUT_W-1:RESULT_W] !== '0)
          report($sformatf("pad bits of result beat 0x%06h not zero", beat));
      end
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata;
  logic [TUSER_IN_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;

  quant_scoreboard sb;
  int idle_pct;
  int stall_pct;
  bit hold_pending;

  jpeg_block_quantizer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #3ms;
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_left = 80;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // offer one beat after a random gap and wait for it to be taken
  task send_item(op_t op, logic tsel, logic [POS_W-1:0] pos, logic signed [VALUE_W-1:0] v);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, v, pos};
    s_tuser  <= {tsel, op};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, tsel, pos, v);
  endtask

  // random beat: uniform half the time, else values near rounding midpoints, small ones or extremes
  task send_random();
    op_t op;
    logic tsel;
    logic [POS_W-1:0] pos;
    int q;
    int mag;
    int v;
    int pick;
    op   = op_t'($urandom_range(0, 1));
    tsel = 1'($urandom_range(0, 1));
    pos  = POS_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      v = $signed(16'($urandom));
    end else if (pick < 8) begin
      q = sb.step_size(tsel, pos);
      mag = 8 * q * (2 * $urandom_range(0, 32768 / (16 * q)) + 1) + $urandom_range(0, 2) - 1;
      if (mag > 32767) mag = 32767;
      v = $urandom_range(0, 1) ? -mag : mag;
    end else if (pick < 9) begin
      v = $urandom_range(0, 128) - 64;
    end else begin
      v = $urandom_range(0, 1) ? -32768 : 32767;
    end
    send_item(op, tsel, pos, 16'(v));
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    hold_pending = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // quantize midpoints and extremes, luma dc entry
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, 16'sd0);
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, 16'sd127);
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, 16'sd128);
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, -16'sd128);
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, -16'sd127);
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, 16'sd383);
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, 16'sd384);
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, 16'sd32767);
    send_item(OP_QUANT, TABLE_LUMA, 6'd0, -16'sd32768);
    // odd entry midpoints, chroma dc
    send_item(OP_QUANT, TABLE_CHROMA, 6'd0, 16'sd136);
    send_item(OP_QUANT, TABLE_CHROMA, 6'd0, -16'sd136);
    send_item(OP_QUANT, TABLE_CHROMA, 6'd0, 16'sd135);
    // largest entry, last position and smallest entry
    send_item(OP_QUANT, TABLE_LUMA, 6'd53, 16'sd32767);
    send_item(OP_QUANT, TABLE_LUMA, 6'd53, -16'sd32768);
    send_item(OP_QUANT, TABLE_CHROMA, 6'd63, -16'sd32768);
    send_item(OP_QUANT, TABLE_CHROMA, 6'd63, 16'sd792);
    send_item(OP_QUANT, TABLE_LUMA, 6'd2, 16'sd80);
    send_item(OP_QUANT, TABLE_LUMA, 6'd2, -16'sd80);
    // dequantize, including the largest product
    send_item(OP_DEQUANT, TABLE_LUMA, 6'd53, -16'sd32768);
    send_item(OP_DEQUANT, TABLE_LUMA, 6'd53, 16'sd32767);
    send_item(OP_DEQUANT, TABLE_CHROMA, 6'd63, 16'sd1);
    send_item(OP_DEQUANT, TABLE_CHROMA, 6'd63, -16'sd1);
    send_item(OP_DEQUANT, TABLE_LUMA, 6'd2, 16'sd0);
    send_item(OP_DEQUANT, TABLE_LUMA, 6'd0, -16'sd32768);

    // back to back, with one long hold-off so the pipeline fills
    hold_pending = 1'b1;
    repeat (400) send_random();
    drain();

    // sender idle
    idle_pct = 56;
    stall_pct = 0;
    repeat (400) send_random();
    drain();

    // receiver stalls
    idle_pct = 0;
    stall_pct = 56;
    repeat (400) send_random();
    drain();

    // both
    idle_pct = 35;
    stall_pct = 35;
    repeat (400) send_random();
    drain();

    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
